### rtl/glpf_pkg.sv
// shared types, constants and digit helpers for the grid locator position formatter
package glpf_pkg;

  localparam int unsigned FRAME_LEN = 20;
  localparam int unsigned CNT_W     = 5;

  // configuration register indexes
  localparam logic [1:0] REG_TYPE_INDICATOR = 2'd0;
  localparam logic [1:0] REG_DEF_SYM_TABLE  = 2'd1;
  localparam logic [1:0] REG_DEF_SYM_CODE   = 2'd2;

  // register reset values
  localparam logic [7:0] RST_TYPE_INDICATOR = 8'd33;
  localparam logic [7:0] RST_DEF_SYM_TABLE  = 8'd47;
  localparam logic [7:0] RST_DEF_SYM_CODE   = 8'd62;

  // ascii characters
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_R = 8'h52;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_NORTH   = 8'h4E;
  localparam logic [7:0] CH_SOUTH   = 8'h53;
  localparam logic [7:0] CH_EAST    = 8'h45;
  localparam logic [7:0] CH_WEST    = 8'h57;
  localparam logic [7:0] CASE_FOLD  = 8'h20;

  typedef logic [FRAME_LEN-1:0][7:0] frame_t;

  // one accepted locator beat
  typedef struct packed {
    logic [5:0][7:0] loc_char;
    logic [3:0]      loc_length;
    logic [7:0]      symbol_table;
    logic [7:0]      symbol_code;
  } glpf_item_t;

  // configuration registers
  typedef struct packed {
    logic [7:0] type_indicator;
    logic [7:0] default_symbol_table;
    logic [7:0] default_symbol_code;
  } glpf_cfg_t;

  // decoded frame handed to the serializer
  typedef struct packed {
    logic   bad;
    frame_t frame;
  } glpf_frame_t;

  // split a value below 200 into hundreds, tens and ones digits
  function automatic logic [11:0] dec3(input logic [7:0] v);
    logic        h;
    logic [6:0]  r;
    logic [14:0] p;
    logic [3:0]  t;
    logic [6:0]  o;
    h = (v >= 8'd100);
    r = h ? 7'(v - 8'd100) : v[6:0];
    // divide by ten through reciprocal, exact below 1029
    p = 15'(r) * 15'd205;
    t = p[14:11];
    o = r - 7'(7'(t) * 7'd10);
    return {3'b000, h, t, o[3:0]};
  endfunction

  function automatic logic [7:0] dig_char(input logic [3:0] d);
    return CH_ZERO | {4'h0, d};
  endfunction

endpackage

### rtl/glpf_decode.sv
// locator check and frame build from one registered locator beat
module glpf_decode (
  input  glpf_pkg::glpf_item_t  item_i,
  input  glpf_pkg::glpf_cfg_t   cfg_i,
  output glpf_pkg::glpf_frame_t frame_o
);
  import glpf_pkg::*;

  logic [7:0] c0, c1, c2, c3, c4, c5, c4f, c5f;
  logic       len4, len6, ok_base, ok6, ok;
  logic [7:0] d0, d1, d2, d3, d4, d5;
  logic [4:0] f0, f1, s4, s5;
  logic [3:0] s2, s3;
  logic [8:0] lon_e, lon_g;
  logic [7:0] lat_d;
  logic       lat_neg, lon_neg;
  logic [7:0] lat_deg, lon_deg;
  logic [6:0] lat_min, lat_hund, lon_min, lon_hund;
  logic [5:0] k5, t5;
  logic       lon_o;
  logic [4:0] lon_t;
  logic [11:0] lat_deg_dg, lat_min_dg, lat_hund_dg, lon_deg_dg, lon_min_dg, lon_hund_dg;
  frame_t     fr;

  assign c0 = item_i.loc_char[0];
  assign c1 = item_i.loc_char[1];
  assign c2 = item_i.loc_char[2];
  assign c3 = item_i.loc_char[3];
  assign c4 = item_i.loc_char[4];
  assign c5 = item_i.loc_char[5];

  // validity checks, subsquare letters folded to lower case
  always_comb begin
    len4 = (item_i.loc_length == 4'd4);
    len6 = (item_i.loc_length == 4'd6);
    ok_base = (len4 || len6) &&
              (c0 >= CH_UPPER_A) && (c0 <= CH_UPPER_R) &&
              (c1 >= CH_UPPER_A) && (c1 <= CH_UPPER_R) &&
              (c2 >= CH_ZERO) && (c2 <= CH_NINE) &&
              (c3 >= CH_ZERO) && (c3 <= CH_NINE);
    c4f = ((c4 >= CH_UPPER_A) && (c4 <= CH_UPPER_X)) ? (c4 + CASE_FOLD) : c4;
    c5f = ((c5 >= CH_UPPER_A) && (c5 <= CH_UPPER_X)) ? (c5 + CASE_FOLD) : c5;
    ok6 = (c4f >= CH_LOWER_A) && (c4f <= CH_LOWER_X) &&
          (c5f >= CH_LOWER_A) && (c5f <= CH_LOWER_X);
    ok  = ok_base && (len4 || ok6);
  end

  // letter and digit offsets
  always_comb begin
    d0 = c0 - CH_UPPER_A;
    d1 = c1 - CH_UPPER_A;
    d2 = c2 - CH_ZERO;
    d3 = c3 - CH_ZERO;
    d4 = c4f - CH_LOWER_A;
    d5 = c5f - CH_LOWER_A;
    f0 = d0[4:0];
    f1 = d1[4:0];
    s2 = d2[3:0];
    s3 = d3[3:0];
    s4 = d4[4:0];
    s5 = d5[4:0];
  end

  // latitude: whole degrees from field and square, fraction from subsquare
  always_comb begin
    lat_d   = 8'(8'({3'b000, f1} * 8'd10) + 8'({4'h0, s3}));
    lat_neg = (lat_d < 8'd90);
    lat_deg = lat_neg ? (8'd89 - lat_d) : (lat_d - 8'd90);
    k5      = 6'({2'b00, s5[4:1]} * 6'd5);
    if (len6) begin
      if (!lat_neg) begin
        lat_min  = 7'({1'b0, k5}) + (s5[0] ? 7'd3 : 7'd1);
        lat_hund = s5[0] ? 7'd75 : 7'd25;
      end else begin
        lat_min  = (s5[0] ? 7'd56 : 7'd58) - 7'({1'b0, k5});
        lat_hund = s5[0] ? 7'd25 : 7'd75;
      end
    end else begin
      lat_min  = 7'd30;
      lat_hund = 7'd0;
    end
  end

  // longitude: two degrees per square, subsquare of five minutes
  always_comb begin
    lon_e = 9'(9'({4'h0, f0} * 9'd20) + 9'({4'h0, s2, 1'b0}));
    lon_o = (s4 >= 5'd12);
    lon_t = lon_o ? (s4 - 5'd12) : s4;
    lon_g = lon_e + 9'({8'h00, lon_o});
    t5    = 6'({2'b00, lon_t[3:0]} * 6'd5);
    if (len6) begin
      lon_neg  = (lon_g < 9'd180);
      lon_deg  = lon_neg ? 8'(9'd179 - lon_g) : 8'(lon_g - 9'd180);
      lon_min  = lon_neg ? (7'd57 - 7'({1'b0, t5})) : (7'({1'b0, t5}) + 7'd2);
      lon_hund = 7'd50;
    end else begin
      lon_neg  = (lon_e < 9'd179);
      lon_deg  = lon_neg ? 8'(9'd179 - lon_e) : 8'(lon_e - 9'd179);
      lon_min  = 7'd0;
      lon_hund = 7'd0;
    end
  end

  // decimal digits
  always_comb begin
    lat_deg_dg  = dec3(lat_deg);
    lat_min_dg  = dec3({1'b0, lat_min});
    lat_hund_dg = dec3({1'b0, lat_hund});
    lon_deg_dg  = dec3(lon_deg);
    lon_min_dg  = dec3({1'b0, lon_min});
    lon_hund_dg = dec3({1'b0, lon_hund});
  end

  // frame assembly, first character at index zero
  always_comb begin
    fr     = '0;
    fr[0]  = ok ? cfg_i.type_indicator : 8'h00;
    fr[1]  = dig_char(lat_deg_dg[7:4]);
    fr[2]  = dig_char(lat_deg_dg[3:0]);
    fr[3]  = dig_char(lat_min_dg[7:4]);
    fr[4]  = dig_char(lat_min_dg[3:0]);
    fr[5]  = CH_DOT;
    fr[6]  = dig_char(lat_hund_dg[7:4]);
    fr[7]  = dig_char(lat_hund_dg[3:0]);
    fr[8]  = lat_neg ? CH_SOUTH : CH_NORTH;
    fr[9]  = (item_i.symbol_table != 8'h00) ? item_i.symbol_table
                                            : cfg_i.default_symbol_table;
    fr[10] = dig_char(lon_deg_dg[11:8]);
    fr[11] = dig_char(lon_deg_dg[7:4]);
    fr[12] = dig_char(lon_deg_dg[3:0]);
    fr[13] = dig_char(lon_min_dg[7:4]);
    fr[14] = dig_char(lon_min_dg[3:0]);
    fr[15] = CH_DOT;
    fr[16] = dig_char(lon_hund_dg[7:4]);
    fr[17] = dig_char(lon_hund_dg[3:0]);
    fr[18] = lon_neg ? CH_WEST : CH_EAST;
    fr[19] = (item_i.symbol_code != 8'h00) ? item_i.symbol_code
                                           : cfg_i.default_symbol_code;
  end

  assign frame_o.bad   = !ok;
  assign frame_o.frame = fr;

endmodule

### rtl/glpf_serializer.sv
// frame register: one character beat out per cycle unless stalled
module glpf_serializer (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  glpf_pkg::glpf_frame_t frame_i,
  output logic                  free_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            out_char_o,
  output logic                  last_o,
  output logic                  bad_locator_o
);
  import glpf_pkg::*;

  frame_t           frame_q;
  logic             bad_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             fire;

  assign fire   = out_valid_o && !out_stall_i;
  assign free_o = (cnt_q == '0) || (fire && (cnt_q == CNT_W'(1)));

  // remaining beat count
  always_comb begin
    cnt_d = cnt_q;
    if (load_i) begin
      cnt_d = frame_i.bad ? CNT_W'(1) : CNT_W'(FRAME_LEN);
    end else if (fire) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // frame payload, shifted toward index zero on each beat
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      frame_q <= frame_i.frame;
      bad_q   <= frame_i.bad;
    end else if (fire) begin
      for (int i = 0; i < FRAME_LEN - 1; i++) begin
        frame_q[i] <= frame_q[i+1];
      end
      frame_q[FRAME_LEN-1] <= 8'h00;
    end
  end

  assign out_valid_o   = (cnt_q != '0);
  assign out_char_o    = frame_q[0];
  assign last_o        = (cnt_q == CNT_W'(1));
  assign bad_locator_o = bad_q;

endmodule

### rtl/grid_locator_position_formatter_core.sv
// top level: maidenhead locator to uncompressed position frame formatter
//
// Input channel: one beat carries a locator (six characters and a length) and
// two symbol characters; accepted when in_valid_i is high and in_stall_o low.
// Output channel: one beat per frame character; accepted when out_valid_o is
// high and out_stall_i low. A good locator yields twenty beats, the last one
// flagged by last_o; a bad locator yields one beat with out_char_o zero and
// both last_o and bad_locator_o high.
// Configuration: cfg_valid_i with cfg_index_i and cfg_data_i writes one of the
// three character registers; cfg_ready_o is always high.
// Path: an accepted beat passes the input register, then the frame register,
// before its first character appears. Throughput is set by the one-character
// output channel. The next locator waits in the input register while a frame
// drains and moves into the frame register in the cycle the last beat leaves.
// Reset clears both stages and loads the registers with '!', '/' and '>'.
// A stalled receiver holds the current character; once the input register is
// also full, in_stall_o goes high.
module grid_locator_position_formatter_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] loc_char0_i,
  input  logic [7:0] loc_char1_i,
  input  logic [7:0] loc_char2_i,
  input  logic [7:0] loc_char3_i,
  input  logic [7:0] loc_char4_i,
  input  logic [7:0] loc_char5_i,
  input  logic [3:0] loc_length_i,
  input  logic [7:0] symbol_table_i,
  input  logic [7:0] symbol_code_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       last_o,
  output logic       bad_locator_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);
  import glpf_pkg::*;

  glpf_item_t  item_q;
  logic        item_vld_q, item_vld_d;
  glpf_cfg_t   cfg_q;
  glpf_frame_t frame;
  logic        ser_free, ser_load, in_fire;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.type_indicator       <= RST_TYPE_INDICATOR;
      cfg_q.default_symbol_table <= RST_DEF_SYM_TABLE;
      cfg_q.default_symbol_code  <= RST_DEF_SYM_CODE;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_TYPE_INDICATOR: cfg_q.type_indicator       <= cfg_data_i;
        REG_DEF_SYM_TABLE:  cfg_q.default_symbol_table <= cfg_data_i;
        REG_DEF_SYM_CODE:   cfg_q.default_symbol_code  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register handshake
  assign in_stall_o = item_vld_q && !ser_free;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign ser_load   = item_vld_q && ser_free;

  always_comb begin
    item_vld_d = item_vld_q;
    if (in_fire) begin
      item_vld_d = 1'b1;
    end else if (ser_load) begin
      item_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else begin
      item_vld_q <= item_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.loc_char[0]  <= loc_char0_i;
      item_q.loc_char[1]  <= loc_char1_i;
      item_q.loc_char[2]  <= loc_char2_i;
      item_q.loc_char[3]  <= loc_char3_i;
      item_q.loc_char[4]  <= loc_char4_i;
      item_q.loc_char[5]  <= loc_char5_i;
      item_q.loc_length   <= loc_length_i;
      item_q.symbol_table <= symbol_table_i;
      item_q.symbol_code  <= symbol_code_i;
    end
  end

  // locator check and frame build
  glpf_decode u_decode (
    .item_i  (item_q),
    .cfg_i   (cfg_q),
    .frame_o (frame)
  );

  // character output stage
  glpf_serializer u_serializer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (ser_load),
    .frame_i       (frame),
    .free_o        (ser_free),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_char_o    (out_char_o),
    .last_o        (last_o),
    .bad_locator_o (bad_locator_o)
  );

endmodule

### tb/tb.sv
// testbench for the grid locator position formatter: locator beats in, position frame chars out
module tb;
  import glpf_pkg::*;

  // grid geometry: steps and midpoints in hundredths of minutes, sizes and shifts in degrees
  localparam int HMIN_PER_DEG   = 6000;
  localparam int SQUARE_LAT_MID = 3000;
  localparam int SQUARE_LON_MID = 6000;
  localparam int SUB_LON_STEP   = 500;
  localparam int SUB_LON_MID    = 250;
  localparam int SUB_LAT_STEP   = 250;
  localparam int SUB_LAT_MID    = 125;
  localparam int FIELD_LON_DEG  = 20;
  localparam int FIELD_LAT_DEG  = 10;
  localparam int SQUARE_LON_DEG = 2;
  localparam int LAT_SHIFT_DEG  = 90;
  localparam int LON_SHIFT_DEG  = 180;

  localparam logic [1:0] REG_UNUSED   = 2'd3;
  localparam int         DRAIN_CYCLES = 6;
  localparam int         HOLD_CYCLES  = 150;
  localparam int         IDLE_LIMIT   = 3000;
  localparam int         MAX_REPORTS  = 40;
  localparam int         RAND_PER_PHASE = 88;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       bad;
  } frame_char_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY} stall_mode_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] loc_char0_i = 8'h00;
  logic [7:0] loc_char1_i = 8'h00;
  logic [7:0] loc_char2_i = 8'h00;
  logic [7:0] loc_char3_i = 8'h00;
  logic [7:0] loc_char4_i = 8'h00;
  logic [7:0] loc_char5_i = 8'h00;
  logic [3:0] loc_length_i = 4'h0;
  logic [7:0] symbol_table_i = 8'h00;
  logic [7:0] symbol_code_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_char_o;
  logic       last_o;
  logic       bad_locator_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i = 2'd0;
  logic [7:0] cfg_data_i = 8'h00;

  glpf_item_t  locator_q[$];
  frame_char_t frame_chars_q[$];
  glpf_cfg_t   frame_regs = '{RST_TYPE_INDICATOR, RST_DEF_SYM_TABLE, RST_DEF_SYM_CODE};
  glpf_item_t  offered;
  int          mismatches = 0;
  int          chars_seen = 0;
  int          gap_left = 0;
  int          burst_left = 0;
  int          hold_arm = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          mode_left = 0;
  int          idle_cycles = 0;
  stall_mode_e stall_mode = STALL_NONE;

  grid_locator_position_formatter_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .loc_char0_i    (loc_char0_i),
    .loc_char1_i    (loc_char1_i),
    .loc_char2_i    (loc_char2_i),
    .loc_char3_i    (loc_char3_i),
    .loc_char4_i    (loc_char4_i),
    .loc_char5_i    (loc_char5_i),
    .loc_length_i   (loc_length_i),
    .symbol_table_i (symbol_table_i),
    .symbol_code_i  (symbol_code_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_char_o     (out_char_o),
    .last_o         (last_o),
    .bad_locator_o  (bad_locator_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic between(logic [7:0] c, logic [7:0] lo, logic [7:0] hi);
    return c >= lo && c <= hi;
  endfunction

  task automatic push_char(logic [7:0] ch, logic last_flag, logic bad_flag);
    frame_chars_q.push_back('{ch, last_flag, bad_flag});
  endtask

  // zero-padded decimal, most significant digit first
  task automatic push_digits(int unsigned v, int unsigned digits);
    int unsigned scale;
    int unsigned k;
    scale = 1;
    for (k = 1; k < digits; k++) scale *= 10;
    while (scale > 0) begin
      push_char(CH_ZERO + 8'((v / scale) % 10), 1'b0, 1'b0);
      scale /= 10;
    end
  endtask

  // degrees, minutes, '.', hundredths, hemisphere letter
  task automatic push_coord(int hmin, int unsigned whole_width, logic [7:0] pos_ch,
                            logic [7:0] neg_ch);
    int unsigned mag;
    mag = (hmin < 0) ? -hmin : hmin;
    push_digits(mag / HMIN_PER_DEG, whole_width);
    push_digits((mag % HMIN_PER_DEG) / 100, 2);
    push_char(CH_DOT, 1'b0, 1'b0);
    push_digits(mag % 100, 2);
    push_char((hmin < 0) ? neg_ch : pos_ch, 1'b0, 1'b0);
  endtask

  // expected frame chars for one accepted locator beat
  task automatic format_position(glpf_item_t it);
    logic [7:0] c [6];
    logic       ok;
    int         lat;
    int         lon;
    int         k;
    for (k = 0; k < 6; k++) c[k] = it.loc_char[k];
    ok = (it.loc_length == 4'd4 || it.loc_length == 4'd6) &&
         between(c[0], CH_UPPER_A, CH_UPPER_R) && between(c[1], CH_UPPER_A, CH_UPPER_R) &&
         between(c[2], CH_ZERO, CH_NINE) && between(c[3], CH_ZERO, CH_NINE);
    if (ok && it.loc_length == 4'd6) begin
      // subsquare letters fold to lower case
      for (k = 4; k < 6; k++) begin
        if (between(c[k], CH_UPPER_A, CH_UPPER_X)) c[k] = c[k] | CASE_FOLD;
      end
      ok = between(c[4], CH_LOWER_A, CH_LOWER_X) && between(c[5], CH_LOWER_A, CH_LOWER_X);
    end
    if (!ok) begin
      push_char(8'h00, 1'b1, 1'b1);
    end else begin
      lon = ((int'(c[0]) - int'(CH_UPPER_A)) * FIELD_LON_DEG +
             (int'(c[2]) - int'(CH_ZERO)) * SQUARE_LON_DEG) * HMIN_PER_DEG;
      lat = ((int'(c[1]) - int'(CH_UPPER_A)) * FIELD_LAT_DEG +
             (int'(c[3]) - int'(CH_ZERO))) * HMIN_PER_DEG;
      if (it.loc_length == 4'd6) begin
        lon += (int'(c[4]) - int'(CH_LOWER_A)) * SUB_LON_STEP + SUB_LON_MID;
        lat += (int'(c[5]) - int'(CH_LOWER_A)) * SUB_LAT_STEP + SUB_LAT_MID;
      end else begin
        lon += SQUARE_LON_MID;
        lat += SQUARE_LAT_MID;
      end
      lat -= LAT_SHIFT_DEG * HMIN_PER_DEG;
      lon -= LON_SHIFT_DEG * HMIN_PER_DEG;
      push_char(frame_regs.type_indicator, 1'b0, 1'b0);
      push_coord(lat, 2, CH_NORTH, CH_SOUTH);
      push_char((it.symbol_table != 8'h00) ? it.symbol_table
                                            : frame_regs.default_symbol_table, 1'b0, 1'b0);
      push_coord(lon, 3, CH_EAST, CH_WEST);
      push_char((it.symbol_code != 8'h00) ? it.symbol_code
                                           : frame_regs.default_symbol_code, 1'b1, 1'b0);
    end
  endtask

  // ---------------------------------------------------------------- stimulus helpers

  function automatic glpf_item_t make_loc(string s, logic [3:0] len);
    glpf_item_t it;
    int k;
    for (k = 0; k < 6; k++) it.loc_char[k] = (k < s.len()) ? 8'(s[k]) : 8'($urandom);
    it.loc_length   = len;
    it.symbol_table = 8'h00;
    it.symbol_code  = 8'h00;
    return it;
  endfunction

  // well-formed locator with random content
  function automatic glpf_item_t random_locator();
    glpf_item_t it;
    it.loc_char[0] = CH_UPPER_A + 8'($urandom_range(0, 17));
    it.loc_char[1] = CH_UPPER_A + 8'($urandom_range(0, 17));
    it.loc_char[2] = CH_ZERO + 8'($urandom_range(0, 9));
    it.loc_char[3] = CH_ZERO + 8'($urandom_range(0, 9));
    it.loc_char[4] = ($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + 8'($urandom_range(0, 23));
    it.loc_char[5] = ($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + 8'($urandom_range(0, 23));
    it.loc_length  = $urandom_range(0, 1) ? 4'd4 : 4'd6;
    if (it.loc_length == 4'd4 && $urandom_range(0, 1)) begin
      it.loc_char[4] = 8'($urandom);
      it.loc_char[5] = 8'($urandom);
    end
    it.symbol_table = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
    it.symbol_code  = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
    return it;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_TYPE_INDICATOR: frame_regs.type_indicator       = val;
      REG_DEF_SYM_TABLE:  frame_regs.default_symbol_table = val;
      REG_DEF_SYM_CODE:   frame_regs.default_symbol_code  = val;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  // all items sent, all chars back, then let the pipeline settle
  task automatic wait_idle();
    do @(negedge clk_i);
    while (locator_q.size() != 0 || in_valid_i || frame_chars_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic report_mismatch(string field, int got, int want);
    if (mismatches < MAX_REPORTS)
      $display("mismatch at char %0d: %s got %0h expected %0h", chars_seen, field, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------- sender

  // bursts of beats with random gaps; a stalled beat is held
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) format_position(offered);
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (locator_q.size() > 0) begin
          offered = locator_q.pop_front();
          loc_char0_i    <= offered.loc_char[0];
          loc_char1_i    <= offered.loc_char[1];
          loc_char2_i    <= offered.loc_char[2];
          loc_char3_i    <= offered.loc_char[3];
          loc_char4_i    <= offered.loc_char[4];
          loc_char5_i    <= offered.loc_char[5];
          loc_length_i   <= offered.loc_length;
          symbol_table_i <= offered.symbol_table;
          symbol_code_i  <= offered.symbol_code;
          in_valid_i     <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  // stall pattern in random modes, plus a long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (hold_seen != hold_arm) begin
        hold_seen = hold_arm;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = stall_mode_e'($urandom_range(0, 3));
          mode_left  = $urandom_range(10, 80);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          STALL_NONE:  out_stall_i <= 1'b0;
          STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
          STALL_HALF:  out_stall_i <= ($urandom_range(0, 1) == 0);
          default:     out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // compare each accepted char against the oldest expected one
  always @(posedge clk_i) begin
    frame_char_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (frame_chars_q.size() == 0) begin
        report_mismatch("unexpected char", out_char_o, 0);
      end else begin
        want = frame_chars_q.pop_front();
        if (out_char_o !== want.ch) report_mismatch("out_char", out_char_o, want.ch);
        if (last_o !== want.last) report_mismatch("last", last_o, want.last);
        if (bad_locator_o !== want.bad) report_mismatch("bad_locator", bad_locator_o, want.bad);
      end
      chars_seen++;
    end
  end

  // watchdog on cycles with no beat moving on any channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    glpf_item_t it;
    int ph;
    int n;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        wait_idle();
        case (ph)
          1: begin
            write_reg(REG_TYPE_INDICATOR, 8'h00);
            write_reg(REG_DEF_SYM_TABLE, 8'h00);
            write_reg(REG_DEF_SYM_CODE, 8'h00);
            write_reg(REG_UNUSED, 8'hFF);
          end
          2: begin
            write_reg(REG_TYPE_INDICATOR, 8'hFF);
            write_reg(REG_DEF_SYM_TABLE, 8'hFF);
            write_reg(REG_DEF_SYM_CODE, 8'hFF);
          end
          default: begin
            write_reg(REG_DEF_SYM_CODE, 8'($urandom));
            write_reg(REG_TYPE_INDICATOR, 8'($urandom));
            write_reg(REG_DEF_SYM_TABLE, 8'($urandom));
            write_reg(REG_UNUSED, 8'($urandom));
          end
        endcase
      end
      @(negedge clk_i);
      if (ph == 0) begin
        // corners of the grid, defaults and overrides of the symbols
        locator_q.push_back(make_loc("AA00", 4'd4));
        it = make_loc("RR99", 4'd4);
        it.symbol_table = 8'hFF;
        it.symbol_code  = 8'h01;
        locator_q.push_back(it);
        locator_q.push_back(make_loc("AA00aa", 4'd6));
        it = make_loc("RR99xx", 4'd6);
        it.symbol_table = 8'h01;
        it.symbol_code  = 8'hFF;
        locator_q.push_back(it);
        locator_q.push_back(make_loc("RR99XX", 4'd6));
        // just either side of the equator and the prime meridian
        locator_q.push_back(make_loc("JJ00Aa", 4'd6));
        locator_q.push_back(make_loc("II99xX", 4'd6));
        // bad lengths
        locator_q.push_back(make_loc("AA00aa", 4'd0));
        locator_q.push_back(make_loc("AA00aa", 4'd3));
        locator_q.push_back(make_loc("AA00aa", 4'd5));
        locator_q.push_back(make_loc("AA00aa", 4'd7));
        locator_q.push_back(make_loc("AA00aa", 4'd15));
        // characters just outside each accepted span
        locator_q.push_back(make_loc("@A00", 4'd4));
        locator_q.push_back(make_loc("SA00", 4'd4));
        locator_q.push_back(make_loc("AS00", 4'd4));
        locator_q.push_back(make_loc("AA/0", 4'd4));
        locator_q.push_back(make_loc("AA0:", 4'd4));
        locator_q.push_back(make_loc("AA00`a", 4'd6));
        locator_q.push_back(make_loc("AA00ay", 4'd6));
        locator_q.push_back(make_loc("AA00Ya", 4'd6));
        locator_q.push_back(make_loc("AA00a@", 4'd6));
        locator_q.push_back(make_loc("aa00", 4'd4));
        // four chars long: trailing chars are don't-care
        it = make_loc("FN31", 4'd4);
        it.loc_char[4] = 8'hFF;
        it.loc_char[5] = 8'h00;
        locator_q.push_back(it);
      end
      for (n = 0; n < RAND_PER_PHASE; n++) begin
        it = random_locator();
        case ($urandom_range(0, 19))
          0, 1, 2: it.loc_char[$urandom_range(0, 5)] = 8'($urandom);
          3:       it.loc_length = 4'($urandom);
          4: begin
            it = make_loc("", 4'($urandom));
            it.symbol_table = 8'($urandom);
            it.symbol_code  = 8'($urandom);
          end
          default: ;
        endcase
        locator_q.push_back(it);
      end
      // long receiver hold-off so the input side backs up
      if (ph == 1 || ph == 3) hold_arm++;
    end
    wait_idle();
    if (mismatches == 0 && frame_chars_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
